>>> sv/qrm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrm_pkg
// shared types, widths and lane indexes of the quaternion to matrix unit
// ----------------------------------------------------------------------------
package qrm_pkg;

    localparam int PART_W            = 16;  // quaternion part width, Q3.12
    localparam int PROD_W            = 32;  // signed product of two parts
    localparam int N_W               = 33;  // sum of four squares
    localparam int NUM_W             = 35;  // signed numerator
    localparam int ENT_W             = 16;  // output entry width
    localparam int N_ENT             = 9;
    localparam int N_PROD            = 10;
    localparam int THR_W             = 10;
    localparam logic [THR_W-1:0] THR_RESET = 10'd1;
    localparam int OUT_FRAC_BITS_DEF = 14;

    // product slots
    localparam int P_TT = 0;
    localparam int P_XX = 1;
    localparam int P_YY = 2;
    localparam int P_ZZ = 3;
    localparam int P_XY = 4;
    localparam int P_XZ = 5;
    localparam int P_XT = 6;
    localparam int P_YZ = 7;
    localparam int P_YT = 8;
    localparam int P_ZT = 9;

    // entry lanes, column by column
    localparam int E_R0C0 = 0;
    localparam int E_R1C0 = 1;
    localparam int E_R2C0 = 2;
    localparam int E_R0C1 = 3;
    localparam int E_R1C1 = 4;
    localparam int E_R2C1 = 5;
    localparam int E_R0C2 = 6;
    localparam int E_R1C2 = 7;
    localparam int E_R2C2 = 8;

    localparam logic [N_ENT-1:0] DIAG_MASK = 9'b100010001;

    typedef struct packed {
        logic signed [PART_W-1:0] q_scalar;
        logic signed [PART_W-1:0] q_i;
        logic signed [PART_W-1:0] q_j;
        logic signed [PART_W-1:0] q_k;
    } t_quat_in;

    typedef struct packed {
        logic signed [ENT_W-1:0] m_r0c0;
        logic signed [ENT_W-1:0] m_r1c0;
        logic signed [ENT_W-1:0] m_r2c0;
        logic signed [ENT_W-1:0] m_r0c1;
        logic signed [ENT_W-1:0] m_r1c1;
        logic signed [ENT_W-1:0] m_r2c1;
        logic signed [ENT_W-1:0] m_r0c2;
        logic signed [ENT_W-1:0] m_r1c2;
        logic signed [ENT_W-1:0] m_r2c2;
        logic                    zero_norm;
    } t_mat_out;

    // norm and numerator magnitudes handed to the divider
    typedef struct packed {
        logic [N_W-1:0]                  n;
        logic [N_ENT-1:0][N_W-1:0]       mag;
        logic [N_ENT-1:0]                neg;
        logic                            zero;
    } t_front;

    function automatic logic signed [PROD_W-1:0] mul_part(
        input logic signed [PART_W-1:0] a,
        input logic signed [PART_W-1:0] b
    );
        logic signed [PROD_W-1:0] a_w;
        logic signed [PROD_W-1:0] b_w;
        a_w = PROD_W'(a);
        b_w = PROD_W'(b);
        return a_w * b_w;
    endfunction

endpackage : qrm_pkg
`default_nettype wire

>>> sv/qrm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrm_front
// products, norm, numerators and their sign and magnitude: three register stages
// ----------------------------------------------------------------------------
module qrm_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_vld,
    input  wire qrm_pkg::t_quat_in i_quat,
    output logic                  o_vld,
    output qrm_pkg::t_front       o_front
);
    import qrm_pkg::*;

    logic                           r_b_vld, r_c_vld, r_d_vld;
    logic signed [PROD_W-1:0]       r_p [N_PROD];
    logic [N_W-1:0]                 r_n;
    logic signed [NUM_W-1:0]        r_num [N_ENT];
    t_front                         r_front;
    logic signed [NUM_W-1:0]        n_num [N_ENT];
    logic signed [NUM_W-1:0]        w_p [N_PROD];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= i_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    // stage one: the ten products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[P_TT] <= mul_part(i_quat.q_scalar, i_quat.q_scalar);
            r_p[P_XX] <= mul_part(i_quat.q_i, i_quat.q_i);
            r_p[P_YY] <= mul_part(i_quat.q_j, i_quat.q_j);
            r_p[P_ZZ] <= mul_part(i_quat.q_k, i_quat.q_k);
            r_p[P_XY] <= mul_part(i_quat.q_i, i_quat.q_j);
            r_p[P_XZ] <= mul_part(i_quat.q_i, i_quat.q_k);
            r_p[P_XT] <= mul_part(i_quat.q_i, i_quat.q_scalar);
            r_p[P_YZ] <= mul_part(i_quat.q_j, i_quat.q_k);
            r_p[P_YT] <= mul_part(i_quat.q_j, i_quat.q_scalar);
            r_p[P_ZT] <= mul_part(i_quat.q_k, i_quat.q_scalar);
        end
    end

    // stage two: norm and numerators
    always_comb begin
        for (int p = 0; p < N_PROD; p++) begin
            w_p[p] = NUM_W'(r_p[p]);
        end
        n_num[E_R0C0] = w_p[P_TT] + w_p[P_XX] - w_p[P_YY] - w_p[P_ZZ];
        n_num[E_R1C1] = w_p[P_TT] - w_p[P_XX] + w_p[P_YY] - w_p[P_ZZ];
        n_num[E_R2C2] = w_p[P_TT] - w_p[P_XX] - w_p[P_YY] + w_p[P_ZZ];
        n_num[E_R1C0] = (w_p[P_XY] + w_p[P_ZT]) <<< 1;
        n_num[E_R0C1] = (w_p[P_XY] - w_p[P_ZT]) <<< 1;
        n_num[E_R2C0] = (w_p[P_XZ] - w_p[P_YT]) <<< 1;
        n_num[E_R0C2] = (w_p[P_XZ] + w_p[P_YT]) <<< 1;
        n_num[E_R2C1] = (w_p[P_YZ] + w_p[P_XT]) <<< 1;
        n_num[E_R1C2] = (w_p[P_YZ] - w_p[P_XT]) <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n <= N_W'($unsigned(r_p[P_TT])) + N_W'($unsigned(r_p[P_XX]))
                 + N_W'($unsigned(r_p[P_YY])) + N_W'($unsigned(r_p[P_ZZ]));
            for (int k = 0; k < N_ENT; k++) begin
                r_num[k] <= n_num[k];
            end
        end
    end

    // stage three: sign and magnitude
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_front.n    <= r_n;
            r_front.zero <= (r_n == '0);
            for (int k = 0; k < N_ENT; k++) begin
                r_front.neg[k] <= r_num[k][NUM_W-1];
                r_front.mag[k] <= r_num[k][NUM_W-1] ? N_W'(-r_num[k]) : N_W'(r_num[k]);
            end
        end
    end

    assign o_vld   = r_d_vld;
    assign o_front = r_front;

endmodule : qrm_front
`default_nettype wire

>>> sv/qrm_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrm_divider
// nine restoring dividers, one quotient bit per stage
// ----------------------------------------------------------------------------
module qrm_divider #(
    parameter int OUT_FRAC_BITS = qrm_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_en,
    input  wire logic                                    i_vld,
    input  wire qrm_pkg::t_front                         i_front,
    output logic                                         o_vld,
    output logic [qrm_pkg::N_ENT-1:0][OUT_FRAC_BITS+1:0] o_quot,
    output logic [qrm_pkg::N_ENT-1:0]                    o_neg,
    output logic                                         o_zero
);
    import qrm_pkg::*;

    localparam int QW  = OUT_FRAC_BITS + 2;  // floor(mag * 2^(F+1) / n)
    localparam int STG = QW;

    logic                  r_vld  [STG];
    logic [N_W-1:0]        r_n    [STG];
    logic [N_ENT-1:0]      r_neg  [STG];
    logic                  r_zero [STG];
    logic [N_W-1:0]        r_rem  [STG][N_ENT];
    logic [QW-1:0]         r_q    [STG][N_ENT];

    genvar s;
    generate
        for (s = 0; s < STG; s++) begin : g_stage
            logic [N_W-1:0] n_rem [N_ENT];
            logic [N_ENT-1:0] n_bit;

            if (s == 0) begin : g_first
                // integer bit: mag never exceeds n
                always_comb begin
                    for (int k = 0; k < N_ENT; k++) begin
                        n_bit[k] = (i_front.mag[k] >= i_front.n);
                        n_rem[k] = n_bit[k] ? i_front.mag[k] - i_front.n : i_front.mag[k];
                    end
                end
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_vld[s] <= 1'b0;
                    end else if (i_en) begin
                        r_vld[s] <= i_vld;
                    end
                end
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_n[s]    <= i_front.n;
                        r_neg[s]  <= i_front.neg;
                        r_zero[s] <= i_front.zero;
                        for (int k = 0; k < N_ENT; k++) begin
                            r_rem[s][k] <= n_rem[k];
                            r_q[s][k]   <= QW'(n_bit[k]);
                        end
                    end
                end
            end else begin : g_step
                logic [N_W:0] w_sh [N_ENT];
                logic [N_W:0] w_df [N_ENT];
                always_comb begin
                    for (int k = 0; k < N_ENT; k++) begin
                        w_sh[k]  = {r_rem[s-1][k], 1'b0};
                        w_df[k]  = w_sh[k] - {1'b0, r_n[s-1]};
                        n_bit[k] = (w_sh[k] >= {1'b0, r_n[s-1]});
                        n_rem[k] = n_bit[k] ? w_df[k][N_W-1:0] : w_sh[k][N_W-1:0];
                    end
                end
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_vld[s] <= 1'b0;
                    end else if (i_en) begin
                        r_vld[s] <= r_vld[s-1];
                    end
                end
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_n[s]    <= r_n[s-1];
                        r_neg[s]  <= r_neg[s-1];
                        r_zero[s] <= r_zero[s-1];
                        for (int k = 0; k < N_ENT; k++) begin
                            r_rem[s][k] <= n_rem[k];
                            r_q[s][k]   <= {r_q[s-1][k][QW-2:0], n_bit[k]};
                        end
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        for (int k = 0; k < N_ENT; k++) begin
            o_quot[k] = r_q[STG-1][k];
        end
    end

    assign o_vld  = r_vld[STG-1];
    assign o_neg  = r_neg[STG-1];
    assign o_zero = r_zero[STG-1];

endmodule : qrm_divider
`default_nettype wire

>>> sv/quaternion_to_rotation_matrix_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_unit
// normalized quaternion to 3x3 rotation matrix, Q3.12 in, Q1.14 out
// ----------------------------------------------------------------------------
// usage
//   input channel: i_valid / i_quat, held off by o_stall; a transfer happens
//   when i_valid is high and o_stall low
//   output channel: o_valid / o_mat, held off by i_stall; one result per item
//   config: i_cfg_we writes i_cfg_wdata into the clean threshold (reset 1);
//   write it only while no item is in flight
// pipeline: 3 front stages, OUT_FRAC_BITS + 2 divider stages and 1 output
//   register lie between the input transfer and o_valid
// throughput: one item per cycle unless stalled; the divider retires one quotient
//   bit per stage for all nine entries, so its stage count sets the latency
// stall: the whole pipe freezes while the output register holds an untaken
//   result, and o_stall then holds off the sender; nothing is lost or doubled
// reset: synchronous, clears all valid bits and sets the threshold to 1
// zero quaternion: identity matrix with zero_norm set
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_unit #(
    parameter int OUT_FRAC_BITS = qrm_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire qrm_pkg::t_quat_in          i_quat,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output qrm_pkg::t_mat_out               o_mat,
    input  wire logic                       i_cfg_we,
    input  wire logic [qrm_pkg::THR_W-1:0]  i_cfg_wdata
);
    import qrm_pkg::*;

    localparam int QW = OUT_FRAC_BITS + 2;
    localparam int MW = OUT_FRAC_BITS + 1;

    logic                        w_en;
    logic                        w_front_vld;
    t_front                      w_front;
    logic                        w_div_vld;
    logic [N_ENT-1:0][QW-1:0]    w_quot;
    logic [N_ENT-1:0]            w_neg;
    logic                        w_zero;

    logic [THR_W-1:0]            r_thr;
    logic                        r_out_valid;
    t_mat_out                    r_out;
    logic signed [ENT_W-1:0]     n_ent [N_ENT];

    // the pipe moves unless a finished result waits on a stalled receiver
    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    qrm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_valid),
        .i_quat  (i_quat),
        .o_vld   (w_front_vld),
        .o_front (w_front)
    );

    qrm_divider #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_front_vld),
        .i_front (w_front),
        .o_vld   (w_div_vld),
        .o_quot  (w_quot),
        .o_neg   (w_neg),
        .o_zero  (w_zero)
    );

    // round half away from zero on the magnitude, then clean, sign, truncate
    always_comb begin
        logic [QW:0]            rnd;
        logic [MW-1:0]          mag;
        logic                   neg;
        logic signed [31:0]     val;
        for (int k = 0; k < N_ENT; k++) begin
            rnd = (QW+1)'(w_quot[k]) + (QW+1)'(1);
            mag = rnd[MW:1];
            neg = w_neg[k];
            if (w_zero) begin
                // identity for a zero quaternion
                mag = DIAG_MASK[k] ? {1'b1, {OUT_FRAC_BITS{1'b0}}} : '0;
                neg = 1'b0;
            end
            if (32'(mag) < 32'(r_thr)) begin
                mag = '0;
            end
            val      = neg ? -$signed(32'(mag)) : $signed(32'(mag));
            n_ent[k] = val[ENT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.m_r0c0    <= n_ent[E_R0C0];
            r_out.m_r1c0    <= n_ent[E_R1C0];
            r_out.m_r2c0    <= n_ent[E_R2C0];
            r_out.m_r0c1    <= n_ent[E_R0C1];
            r_out.m_r1c1    <= n_ent[E_R1C1];
            r_out.m_r2c1    <= n_ent[E_R2C1];
            r_out.m_r0c2    <= n_ent[E_R0C2];
            r_out.m_r1c2    <= n_ent[E_R1C2];
            r_out.m_r2c2    <= n_ent[E_R2C2];
            r_out.zero_norm <= w_zero;
        end
    end

    assign o_valid = r_out_valid;
    assign o_mat   = r_out;

`ifndef SYNTHESIS
    // a zero quaternion leaves every off-diagonal entry at zero
    a_zero_offdiag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_mat.zero_norm) |-> (o_mat.m_r1c0 == '0 && o_mat.m_r2c0 == '0
            && o_mat.m_r0c1 == '0 && o_mat.m_r2c1 == '0 && o_mat.m_r0c2 == '0
            && o_mat.m_r1c2 == '0))
        else $error("zero quaternion gave a nonzero off-diagonal entry");

    // a frozen pipe keeps the divider output in place
    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && w_div_vld) |=> (w_div_vld && $stable(w_quot) && $stable(w_neg)))
        else $error("divider output moved during a stall");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");
`endif

endmodule : quaternion_to_rotation_matrix_unit
`default_nettype wire

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the quaternion to rotation matrix unit
// ----------------------------------------------------------------------------
// quaternions are fed through a queue into a clocked driver with random gaps;
// a clocked monitor with random stall compares every matrix, entry by entry,
// against a rational-arithmetic predictor; the clean threshold is swept over
// several values between idle phases, zero and 1023 extremes included
// ----------------------------------------------------------------------------
module tb_top;
    import qrm_pkg::*;

    localparam int LATENCY  = OUT_FRAC_BITS_DEF + 6;
    localparam int WD_LIMIT = 20000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_quat_in   i_quat;
    logic       o_valid;
    logic       i_stall;
    t_mat_out   o_mat;
    logic       i_cfg_we;
    logic [THR_W-1:0] i_cfg_wdata;

    quaternion_to_rotation_matrix_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_quat     (i_quat),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_mat      (o_mat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // predictor state and scoreboard
    logic [THR_W-1:0] thr_model;
    t_quat_in   pending_quats[$];
    t_mat_out   expected_mats[$];
    int         n_sent, n_checked, n_errors, n_zero, idle_cycles;
    bit         hold_long;     // set by the stimulus to force a long receiver hold
    bit         timed_out;

    // round(2^14 * num / n), ties away from zero, then clean below threshold
    function automatic logic [ENT_W-1:0] ratio_entry(longint num, longint n);
        longint mag, q;
        mag = num < 0 ? -num : num;
        q   = ((mag << OUT_FRAC_BITS_DEF) * 2 + n) / (2 * n);
        if (q < longint'(thr_model)) q = 0;
        return ENT_W'(num < 0 ? -q : q);
    endfunction

    function automatic t_mat_out rotation_of(t_quat_in qv);
        t_mat_out m;
        longint t, x, y, z, n;
        t = qv.q_scalar; x = qv.q_i; y = qv.q_j; z = qv.q_k;
        n = t*t + x*x + y*y + z*z;
        if (n == 0) begin
            m = '0;
            m.m_r0c0 = 16'sd16384;
            m.m_r1c1 = 16'sd16384;
            m.m_r2c2 = 16'sd16384;
            m.zero_norm = 1'b1;
        end else begin
            m.m_r0c0 = ratio_entry(t*t + x*x - y*y - z*z, n);
            m.m_r1c0 = ratio_entry(2 * (x*y + z*t), n);
            m.m_r2c0 = ratio_entry(2 * (x*z - y*t), n);
            m.m_r0c1 = ratio_entry(2 * (x*y - z*t), n);
            m.m_r1c1 = ratio_entry(t*t - x*x + y*y - z*z, n);
            m.m_r2c1 = ratio_entry(2 * (y*z + x*t), n);
            m.m_r0c2 = ratio_entry(2 * (x*z + y*t), n);
            m.m_r1c2 = ratio_entry(2 * (y*z - x*t), n);
            m.m_r2c2 = ratio_entry(t*t - x*x - y*y + z*z, n);
            m.zero_norm = 1'b0;
        end
        return m;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // driver: offers queued quaternions, payload held while stalled
    int send_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_mats.push_back(rotation_of(i_quat));
                n_sent <= n_sent + 1;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    i_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_quats.size() > 0) begin
                    i_valid  <= 1'b1;
                    i_quat   <= pending_quats.pop_front();
                    send_gap <= gap_len();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random stall, long hold-off on request, entry-by-entry compare
    int stall_cnt;
    always @(posedge i_clk) begin
        t_mat_out e;
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            stall_cnt <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_mats.size() == 0) begin
                    $error("matrix transfer with nothing expected");
                    n_errors <= n_errors + 1;
                end else begin
                    e = expected_mats.pop_front();
                    if (o_mat !== e) begin
                        n_errors <= n_errors + 1;
                        if (o_mat.m_r0c0 !== e.m_r0c0)
                            $error("m_r0c0 exp %0d got %0d", e.m_r0c0, o_mat.m_r0c0);
                        if (o_mat.m_r1c0 !== e.m_r1c0)
                            $error("m_r1c0 exp %0d got %0d", e.m_r1c0, o_mat.m_r1c0);
                        if (o_mat.m_r2c0 !== e.m_r2c0)
                            $error("m_r2c0 exp %0d got %0d", e.m_r2c0, o_mat.m_r2c0);
                        if (o_mat.m_r0c1 !== e.m_r0c1)
                            $error("m_r0c1 exp %0d got %0d", e.m_r0c1, o_mat.m_r0c1);
                        if (o_mat.m_r1c1 !== e.m_r1c1)
                            $error("m_r1c1 exp %0d got %0d", e.m_r1c1, o_mat.m_r1c1);
                        if (o_mat.m_r2c1 !== e.m_r2c1)
                            $error("m_r2c1 exp %0d got %0d", e.m_r2c1, o_mat.m_r2c1);
                        if (o_mat.m_r0c2 !== e.m_r0c2)
                            $error("m_r0c2 exp %0d got %0d", e.m_r0c2, o_mat.m_r0c2);
                        if (o_mat.m_r1c2 !== e.m_r1c2)
                            $error("m_r1c2 exp %0d got %0d", e.m_r1c2, o_mat.m_r1c2);
                        if (o_mat.m_r2c2 !== e.m_r2c2)
                            $error("m_r2c2 exp %0d got %0d", e.m_r2c2, o_mat.m_r2c2);
                        if (o_mat.zero_norm !== e.zero_norm)
                            $error("zero_norm exp %0d got %0d", e.zero_norm,
                                   o_mat.zero_norm);
                    end
                    if (e.zero_norm) n_zero <= n_zero + 1;
                    n_checked <= n_checked + 1;
                end
            end
            // stall length counted here; a long hold lets the pipe fill up
            if (stall_cnt > 0) begin
                i_stall   <= 1'b1;
                stall_cnt <= stall_cnt - 1;
            end else if (hold_long) begin
                i_stall   <= 1'b1;
                stall_cnt <= 200;
            end else if (gap_len() > 0) begin
                i_stall   <= 1'b1;
                stall_cnt <= gap_len();
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic add_quat(int t, int x, int y, int z);
        t_quat_in qv;
        qv.q_scalar = PART_W'(t);
        qv.q_i      = PART_W'(x);
        qv.q_j      = PART_W'(y);
        qv.q_k      = PART_W'(z);
        pending_quats.push_back(qv);
    endtask

    // random quaternion: mostly full range, some small parts, some near-axis
    task automatic add_random_quat();
        int mode;
        t_quat_in qv;
        mode = $urandom_range(0, 9);
        qv = t_quat_in'({$urandom, $urandom});
        if (mode < 2) begin
            qv.q_scalar = PART_W'($signed($urandom_range(0, 15)) - 8);
            qv.q_i      = PART_W'($signed($urandom_range(0, 15)) - 8);
            qv.q_j      = PART_W'($signed($urandom_range(0, 15)) - 8);
            qv.q_k      = PART_W'($signed($urandom_range(0, 15)) - 8);
        end else if (mode < 4) begin
            qv.q_i = PART_W'($signed($urandom_range(0, 63)) - 32);
            qv.q_j = PART_W'($signed($urandom_range(0, 63)) - 32);
        end
        pending_quats.push_back(qv);
    endtask

    task automatic drain();
        while (pending_quats.size() > 0 || expected_mats.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_threshold(logic [THR_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        thr_model    = v;
    endtask

    logic [THR_W-1:0] thr_sweep[5] = '{10'd0, 10'd1023, 10'd3, 10'd40, 10'd512};

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0; i_quat = '0;
        i_cfg_we = 1'b0; i_cfg_wdata = '0;
        n_sent = 0; n_checked = 0; n_errors = 0; n_zero = 0; idle_cycles = 0;
        hold_long = 1'b0; timed_out = 1'b0;
        thr_model = THR_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero, unit axes, extremes, mixed signs, tiny values
        add_quat(0, 0, 0, 0);
        add_quat(4096, 0, 0, 0);
        add_quat(0, 4096, 0, 0);
        add_quat(0, 0, 4096, 0);
        add_quat(0, 0, 0, 4096);
        add_quat(-32768, -32768, -32768, -32768);
        add_quat(32767, 32767, 32767, 32767);
        add_quat(-32768, 0, 0, 0);
        add_quat(32767, -32768, 32767, -32768);
        add_quat(1, 0, 0, 0);
        add_quat(1, 1, 0, 0);
        add_quat(0, -1, 1, -1);
        add_quat(2896, 2896, 0, 0);
        add_quat(2048, 2048, 2048, 2048);
        add_quat(1, 1, 1, 1);
        add_quat(3, -7, 11, -13);
        add_quat(-1, 0, 0, 0);
        add_quat(0, 0, 0, -32768);
        drain();

        // random phases across the threshold sweep, the reset value first
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) set_threshold(thr_sweep[ph-1]);
            for (int k = 0; k < 125; k++) begin
                if ($urandom_range(0, 19) == 0) add_quat(0, 0, 0, 0);
                else add_random_quat();
            end
            if (ph == 2) begin
                // long receiver hold while items keep arriving; held until taken up
                @(posedge i_clk);
                hold_long = 1'b1;
                wait (stall_cnt > 100);
                hold_long = 1'b0;
            end
            drain();
        end

        $display("ran %0d quaternions, %0d matrices checked, %0d zero-norm cases",
                 n_sent, n_checked, n_zero);
        $display("clean threshold swept over 1, 0, 1023, 3, 40, 512");
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
